### hdl/dmn_pkg.sv
// shared types and constants for the division magic number calculator
// microcode word layout, datapath ops, jump conditions and step addresses
// no dependencies
package dmn_pkg;

  localparam logic [31:0]        MSB_ONLY  = 32'h8000_0000;
  localparam logic signed [31:0] NEVER_NEG = 32'sh8000_0000;
  localparam logic signed [31:0] NEVER_POS = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MINUS_ONE = -32'sd1;
  localparam logic [4:0]         DIV_LAST  = 5'd30;
  localparam logic [5:0]         SH_BASE   = 6'd31;

  typedef logic [3:0] uaddr_t;

  // step addresses of the control program
  localparam uaddr_t S_IDLE = 4'd0;
  localparam uaddr_t S_ZCHK = 4'd1;
  localparam uaddr_t S_NORM = 4'd2;
  localparam uaddr_t S_P2   = 4'd3;
  localparam uaddr_t S_DIV  = 4'd4;
  localparam uaddr_t S_RND  = 4'd5;
  localparam uaddr_t S_BAD  = 4'd6;
  localparam uaddr_t S_PWR  = 4'd7;
  localparam uaddr_t S_OUT  = 4'd8;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_NORM,
    OP_DIVINIT,
    OP_DIVSTEP,
    OP_ROUND,
    OP_BAD,
    OP_PWR,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_REQ,
    COND_ZERO,
    COND_NOTNORM,
    COND_POW2,
    COND_DIVMORE,
    COND_OUTBUSY
  } cond_t;

  typedef struct packed {
    op_t    op;
    cond_t  cond;
    uaddr_t tgt_t;
    uaddr_t tgt_f;
  } uword_t;

  typedef struct packed {
    logic zero;
    logic not_norm;
    logic pow2;
    logic div_more;
  } dp_stat_t;

  typedef struct packed {
    dp_stat_t dp;
    logic     req;
    logic     out_busy;
  } cond_in_t;

  typedef struct packed {
    logic [31:0]        mult;
    logic [5:0]         shamt;
    logic signed [31:0] neg;
    logic signed [31:0] pos;
    logic               bad;
  } res_t;

endpackage

### hdl/dmn_ucode_rom.sv
// control program of the magic number calculator, one word per step
// depends on dmn_pkg
module dmn_ucode_rom (
  input  dmn_pkg::uaddr_t addr,
  output dmn_pkg::uword_t word
);

  always_comb begin
    unique case (addr)
      dmn_pkg::S_IDLE: word = '{dmn_pkg::OP_LOAD, dmn_pkg::COND_REQ,
                                dmn_pkg::S_ZCHK, dmn_pkg::S_IDLE};
      dmn_pkg::S_ZCHK: word = '{dmn_pkg::OP_NONE, dmn_pkg::COND_ZERO,
                                dmn_pkg::S_BAD, dmn_pkg::S_NORM};
      // shift the divisor up until its top bit is set
      dmn_pkg::S_NORM: word = '{dmn_pkg::OP_NORM, dmn_pkg::COND_NOTNORM,
                                dmn_pkg::S_NORM, dmn_pkg::S_P2};
      dmn_pkg::S_P2:   word = '{dmn_pkg::OP_DIVINIT, dmn_pkg::COND_POW2,
                                dmn_pkg::S_PWR, dmn_pkg::S_DIV};
      // one quotient bit per step
      dmn_pkg::S_DIV:  word = '{dmn_pkg::OP_DIVSTEP, dmn_pkg::COND_DIVMORE,
                                dmn_pkg::S_DIV, dmn_pkg::S_RND};
      dmn_pkg::S_RND:  word = '{dmn_pkg::OP_ROUND, dmn_pkg::COND_ALWAYS,
                                dmn_pkg::S_OUT, dmn_pkg::S_OUT};
      dmn_pkg::S_BAD:  word = '{dmn_pkg::OP_BAD, dmn_pkg::COND_ALWAYS,
                                dmn_pkg::S_OUT, dmn_pkg::S_OUT};
      dmn_pkg::S_PWR:  word = '{dmn_pkg::OP_PWR, dmn_pkg::COND_ALWAYS,
                                dmn_pkg::S_OUT, dmn_pkg::S_OUT};
      dmn_pkg::S_OUT:  word = '{dmn_pkg::OP_EMIT, dmn_pkg::COND_OUTBUSY,
                                dmn_pkg::S_OUT, dmn_pkg::S_IDLE};
      default:         word = '{dmn_pkg::OP_NONE, dmn_pkg::COND_ALWAYS,
                                dmn_pkg::S_IDLE, dmn_pkg::S_IDLE};
    endcase
  end

endmodule

### hdl/dmn_sequencer.sv
// step counter with conditional jumps over the control program
// depends on dmn_pkg and dmn_ucode_rom
module dmn_sequencer (
  input  logic              clk,
  input  logic              rst_n,
  input  dmn_pkg::cond_in_t cin,
  output dmn_pkg::uword_t   cw
);

  dmn_pkg::uaddr_t upc_r;
  dmn_pkg::uaddr_t upc_nxt;
  logic            take;

  dmn_ucode_rom u_rom (
    .addr (upc_r),
    .word (cw)
  );

  always_comb begin
    unique case (cw.cond)
      dmn_pkg::COND_ALWAYS:  take = 1'b1;
      dmn_pkg::COND_REQ:     take = cin.req;
      dmn_pkg::COND_ZERO:    take = cin.dp.zero;
      dmn_pkg::COND_NOTNORM: take = cin.dp.not_norm;
      dmn_pkg::COND_POW2:    take = cin.dp.pow2;
      dmn_pkg::COND_DIVMORE: take = cin.dp.div_more;
      dmn_pkg::COND_OUTBUSY: take = cin.out_busy;
      default:               take = 1'b1;
    endcase
    upc_nxt = take ? cw.tgt_t : cw.tgt_f;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= dmn_pkg::S_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  a_upc_range: assert property (@(posedge clk) disable iff (!rst_n)
    upc_r <= dmn_pkg::S_OUT)
    else $error("step counter left the program");

  a_idle_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (upc_r == dmn_pkg::S_IDLE && !cin.req) |=> upc_r == dmn_pkg::S_IDLE)
    else $error("left idle without a request");

  a_div_after_p2: assert property (@(posedge clk) disable iff (!rst_n)
    (upc_r == dmn_pkg::S_RND) |-> $past(upc_r) == dmn_pkg::S_DIV)
    else $error("rounding entered without division");

endmodule

### hdl/dmn_datapath.sv
// datapath: normalize shifter, restoring divider and result formatting
// depends on dmn_pkg; driven by the control word op field
module dmn_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  dmn_pkg::op_t      op,
  input  logic              req,
  input  logic [31:0]       divisor,
  output dmn_pkg::dp_stat_t stat,
  output dmn_pkg::res_t     res
);

  logic [31:0]   d_r, d_nxt;
  logic [31:0]   t_r, t_nxt;
  logic [31:0]   p_r, p_nxt;
  logic [4:0]    n_r, n_nxt;
  logic [31:0]   rem_r, rem_nxt;
  logic [30:0]   q_r, q_nxt;
  logic [4:0]    cnt_r, cnt_nxt;
  dmn_pkg::res_t res_r, res_nxt;

  logic [32:0] rem2;
  logic [32:0] rem_sub;
  logic        ge;
  logic        round_up;

  assign rem2     = {rem_r, 1'b0};
  assign rem_sub  = rem2 - {1'b0, d_r};
  assign ge       = rem2 >= {1'b0, d_r};
  // remainder above half the divisor
  assign round_up = rem2 > {1'b0, d_r};

  always_comb begin
    d_nxt   = d_r;
    t_nxt   = t_r;
    p_nxt   = p_r;
    n_nxt   = n_r;
    rem_nxt = rem_r;
    q_nxt   = q_r;
    cnt_nxt = cnt_r;
    res_nxt = res_r;
    unique case (op)
      dmn_pkg::OP_LOAD: begin
        if (req) begin
          d_nxt = divisor;
          t_nxt = divisor;
          p_nxt = dmn_pkg::MSB_ONLY;
          n_nxt = 5'd31;
        end
      end
      dmn_pkg::OP_NORM: begin
        if (!t_r[31]) begin
          t_nxt = {t_r[30:0], 1'b0};
          p_nxt = {1'b0, p_r[31:1]};
          n_nxt = n_r - 5'd1;
        end
      end
      dmn_pkg::OP_DIVINIT: begin
        rem_nxt = p_r;
        q_nxt   = '0;
        cnt_nxt = '0;
      end
      dmn_pkg::OP_DIVSTEP: begin
        rem_nxt = ge ? rem_sub[31:0] : rem2[31:0];
        q_nxt   = {q_r[29:0], ge};
        cnt_nxt = cnt_r + 5'd1;
      end
      dmn_pkg::OP_ROUND: begin
        res_nxt.shamt = dmn_pkg::SH_BASE + {1'b0, n_r};
        res_nxt.bad   = 1'b0;
        if (round_up) begin
          res_nxt.mult = {1'b0, q_r} + 32'd1;
          res_nxt.neg  = dmn_pkg::MINUS_ONE;
          res_nxt.pos  = dmn_pkg::NEVER_POS;
        end else begin
          res_nxt.mult = {1'b0, q_r};
          res_nxt.neg  = dmn_pkg::NEVER_NEG;
          res_nxt.pos  = dmn_pkg::MINUS_ONE;
        end
      end
      dmn_pkg::OP_BAD: begin
        res_nxt.mult  = '0;
        res_nxt.shamt = '0;
        res_nxt.neg   = dmn_pkg::NEVER_NEG;
        res_nxt.pos   = dmn_pkg::NEVER_POS;
        res_nxt.bad   = 1'b1;
      end
      dmn_pkg::OP_PWR: begin
        res_nxt.mult  = 32'd1;
        res_nxt.shamt = {1'b0, n_r};
        res_nxt.neg   = dmn_pkg::NEVER_NEG;
        res_nxt.pos   = dmn_pkg::NEVER_POS;
        res_nxt.bad   = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    d_r   <= d_nxt;
    t_r   <= t_nxt;
    p_r   <= p_nxt;
    n_r   <= n_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    cnt_r <= cnt_nxt;
    res_r <= res_nxt;
  end

  assign stat.zero     = (d_r == '0);
  assign stat.not_norm = !t_r[31];
  assign stat.pow2     = (t_r == dmn_pkg::MSB_ONLY);
  assign stat.div_more = (cnt_r != dmn_pkg::DIV_LAST);
  assign res           = res_r;

  a_rem_below_d: assert property (@(posedge clk) disable iff (!rst_n)
    (op == dmn_pkg::OP_DIVSTEP) |-> rem_r < d_r)
    else $error("partial remainder not below divisor");

  a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
    (op == dmn_pkg::OP_ROUND) |-> q_r[30] == 1'b1)
    else $error("quotient outside [2^30, 2^31)");

endmodule

### hdl/division_magic_number_calc.sv
// top level of the division magic number calculator
// depends on dmn_pkg, dmn_sequencer, dmn_datapath
//
// usage:
//   input channel in_valid/in_stall/in_divisor carries one 32-bit divisor per
//   request; a request is taken when in_valid is high and in_stall is low.
//   result channel out_valid/out_stall carries multiplier, shift_amount,
//   neg_adjust, pos_adjust and bad_divisor; one result per request.
//   a zero divisor gives bad_divisor = 1 with multiplier and shift zeroed.
// sequence:
//   zero check, a normalize loop of one bit per cycle, a restoring division,
//   rounding and an output load; a power of two skips division and rounding,
//   and a zero divisor skips to the error result and the output load.
//   one request in flight; in_stall drops once the result is loaded, so the
//   block takes no new request before the last result is loaded.
// stall and reset:
//   while out_stall holds the result register the sequencer waits in its
//   output step and takes no new request; synchronous active-low reset
//   clears the step counter and out_valid.
module division_magic_number_calc (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [31:0]        in_divisor,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        out_multiplier,
  output logic [5:0]         out_shift_amount,
  output logic signed [31:0] out_neg_adjust,
  output logic signed [31:0] out_pos_adjust,
  output logic               out_bad_divisor
);

  dmn_pkg::uword_t   cw;
  dmn_pkg::cond_in_t cin;
  dmn_pkg::dp_stat_t dstat;
  dmn_pkg::res_t     res;
  dmn_pkg::res_t     out_r;

  logic out_valid_r, out_valid_nxt;
  logic req;
  logic out_busy;
  logic emit;

  // input request only in the idle step of the program
  assign in_stall = (cw.op != dmn_pkg::OP_LOAD);
  assign req      = in_valid && !in_stall;

  // output register is full and the receiver is holding it
  assign out_busy = out_valid_r && out_stall;
  assign emit     = (cw.op == dmn_pkg::OP_EMIT) && !out_busy;

  assign cin.dp       = dstat;
  assign cin.req      = req;
  assign cin.out_busy = out_busy;

  dmn_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .cin   (cin),
    .cw    (cw)
  );

  dmn_datapath u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .op      (cw.op),
    .req     (req),
    .divisor (in_divisor),
    .stat    (dstat),
    .res     (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload, loaded only on emit
  always_ff @(posedge clk) begin
    if (emit) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_multiplier   = out_r.mult;
  assign out_shift_amount = out_r.shamt;
  assign out_neg_adjust   = out_r.neg;
  assign out_pos_adjust   = out_r.pos;
  assign out_bad_divisor  = out_r.bad;

  a_emit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> out_valid_r)
    else $error("emit did not raise out_valid");

  a_good_mult: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.bad) |-> out_r.mult != 32'd0)
    else $error("zero multiplier for a good divisor");

  a_bad_zeroed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.bad) |-> (out_r.mult == 32'd0 && out_r.shamt == 6'd0))
    else $error("error result not zeroed");

  a_one_adjust: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.neg == dmn_pkg::MINUS_ONE && out_r.pos == dmn_pkg::MINUS_ONE))
    else $error("both rounding marks set");

endmodule

### tb/division_magic_number_calc_tb.sv
// self-checking testbench for division_magic_number_calc
// depends on dmn_pkg (result struct and adjust constants) and the block's rtl
// directed and random divisors, both handshakes idled at random, every result checked

module division_magic_number_calc_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // smallest quotient the shift search settles on is just above this
  localparam logic [63:0] QUOT_CEIL   = 64'h3FFF_FFFF;
  localparam int          LONG_HOLD   = 300;  // receiver hold-off, in cycles
  localparam int          SETTLE      = 80;   // a little more than the worst latency
  localparam int          RANDOM_REQS = 430;

  // checker: predicts magic constants per divisor, compares results in order
  class magic_checker;
    logic [31:0]   pending_divisor[$];
    dmn_pkg::res_t pending_magic[$];
    int            mismatches;
    int            checked;
    int            n_zero, n_pow2, n_down, n_up;

    function new();
      mismatches = 0;
      checked    = 0;
      n_zero     = 0;
      n_pow2     = 0;
      n_down     = 0;
      n_up       = 0;
    endfunction

    // multiply-and-shift constants for floor division by d
    function dmn_pkg::res_t calc_magic(logic [31:0] d);
      dmn_pkg::res_t r;
      logic [63:0]   pw, q, rem;
      int unsigned   s;
      r.mult  = '0;
      r.shamt = '0;
      r.neg   = dmn_pkg::NEVER_NEG;
      r.pos   = dmn_pkg::NEVER_POS;
      r.bad   = 1'b0;
      if (d == '0) begin
        r.bad = 1'b1;
      end else begin
        // double the power of two until the quotient passes 2^30 - 1
        pw = 64'd1;
        s  = 0;
        while (s < 63 && (pw / {32'd0, d}) <= QUOT_CEIL) begin
          s++;
          pw = pw << 1;
        end
        q   = pw / {32'd0, d};
        rem = pw % {32'd0, d};
        if (rem == '0) begin
          // exact: d is a power of two, shift by its exponent
          r.mult = 32'd1;
          s = 0;
          while (s < 31 && (32'd1 << s) != d) s++;
        end else if (rem <= {33'd0, d[31:1]}) begin
          r.mult = q[31:0];
          r.pos  = dmn_pkg::MINUS_ONE;
        end else begin
          r.mult = q[31:0] + 32'd1;
          r.neg  = dmn_pkg::MINUS_ONE;
        end
        r.shamt = s[5:0];
      end
      return r;
    endfunction

    function void note_divisor(logic [31:0] d);
      pending_divisor.push_back(d);
      pending_magic.push_back(calc_magic(d));
    endfunction

    function int pending();
      return pending_magic.size();
    endfunction

    function void check_magic(dmn_pkg::res_t got);
      dmn_pkg::res_t want;
      logic [31:0]   d;
      if (pending_magic.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%t: result with no request outstanding: mult %h shift %0d", $realtime,
                   got.mult, got.shamt);
        return;
      end
      want = pending_magic.pop_front();
      d    = pending_divisor.pop_front();
      checked++;
      if (want.bad) n_zero++;
      else if (want.mult == 32'd1) n_pow2++;
      else if (want.pos == dmn_pkg::MINUS_ONE) n_down++;
      else n_up++;
      if (got.mult !== want.mult || got.shamt !== want.shamt || got.neg !== want.neg ||
          got.pos !== want.pos || got.bad !== want.bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%t: divisor %h mismatch", $realtime, d);
          $display("  expected mult %h shift %0d neg %0d pos %0d bad %b",
                   want.mult, want.shamt, want.neg, want.pos, want.bad);
          $display("  actual   mult %h shift %0d neg %0d pos %0d bad %b",
                   got.mult, got.shamt, got.neg, got.pos, got.bad);
        end
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [31:0]        in_divisor;
  logic               out_valid;
  logic               out_stall;
  logic [31:0]        out_multiplier;
  logic [5:0]         out_shift_amount;
  logic signed [31:0] out_neg_adjust;
  logic signed [31:0] out_pos_adjust;
  logic               out_bad_divisor;

  // shared between the request side and the result side
  logic               no_gaps;    // quiet stretch: neither side idles
  int                 hold_asks;  // bumped to ask the result side for a long hold

  magic_checker sb;

  division_magic_number_calc dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_divisor       (in_divisor),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_multiplier   (out_multiplier),
    .out_shift_amount (out_shift_amount),
    .out_neg_adjust   (out_neg_adjust),
    .out_pos_adjust   (out_pos_adjust),
    .out_bad_divisor  (out_bad_divisor)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // idle length: mostly none or short, now and then long
  function automatic int gap_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(30, 120);
  endfunction

  // random divisor spread over zero, powers of two, small, any width and near-power cases
  function automatic logic [31:0] pick_divisor();
    int unsigned kind;
    int unsigned sh;
    logic [31:0] v;
    kind = $urandom_range(0, 99);
    sh   = $urandom_range(2, 31);
    if (kind < 4) v = '0;
    else if (kind < 14) v = 32'd1 << $urandom_range(0, 31);
    else if (kind < 30) v = $urandom_range(1, 1000);
    else if (kind < 60) v = $urandom >> $urandom_range(0, 31);
    else if (kind < 70) v = $urandom_range(0, 1) ? (32'd1 << sh) + 32'd1 : (32'd1 << sh) - 32'd1;
    else v = $urandom;
    return v;
  endfunction

  // offer one request and hold it until taken; valid stays high for a possible next one
  task automatic send_divisor(input logic [31:0] d);
    in_valid   <= 1'b1;
    in_divisor <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_divisor(d);
  endtask

  // random pause on the request side after a request was taken
  task automatic sender_gap();
    int n;
    n = no_gaps ? 0 : gap_len();
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // result side: sample at each edge, then pick the stall for the next cycle
  initial begin
    int            hold_left;
    int            hold_seen;
    dmn_pkg::res_t got;
    hold_left = 0;
    hold_seen = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got.mult  = out_multiplier;
        got.shamt = out_shift_amount;
        got.neg   = out_neg_adjust;
        got.pos   = out_pos_adjust;
        got.bad   = out_bad_divisor;
        sb.check_magic(got);
      end
      // a long hold asked by the request side overrides everything
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (no_gaps) begin
        out_stall <= 1'b0;
      end else begin
        hold_left = gap_len();
        out_stall <= (hold_left > 0);
        if (hold_left > 0) hold_left--;
      end
    end
  end

  // run limit: 450 requests at worst latency plus the longest gap on both sides,
  // the long hold-off, then taken several times over
  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

  // request side and end of run
  initial begin
    logic [31:0] directed [20];
    directed = '{
      32'h0000_0000,  // zero divisor
      32'h0000_0001,  // divisor one
      32'h0000_0002,
      32'h0000_0003,  // rounded down
      32'h0000_0005,
      32'h0000_0006,
      32'h0000_0007,
      32'h0000_0009,  // rounded up
      32'h0000_000B,  // remainder just below half, rounded down
      32'h0000_000A,
      32'h0001_0000,  // power of two mid range
      32'h4000_0000,
      32'h8000_0000,  // largest power of two
      32'h7FFF_FFFF,
      32'h8000_0001,
      32'hFFFF_FFFF,  // largest divisor, deepest shift
      32'hFFFF_FFFE,
      32'hAAAA_AAAA,
      32'h5555_5555,
      32'h0000_0000   // zero again, last in the list
    };
    sb         = new();
    no_gaps    <= 1'b0;
    hold_asks  <= 0;
    in_valid   <= 1'b0;
    in_divisor <= '0;
    rst_n      <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corner cases
    foreach (directed[i]) begin
      send_divisor(directed[i]);
      sender_gap();
    end
    // pause with nothing offered until the block has answered everything
    drain_results();

    for (int i = 0; i < RANDOM_REQS; i++) begin
      // every fourth block of 50 runs with no idling on either side
      if (i % 50 == 0) no_gaps <= ((i / 50) % 4 == 3);
      // result side holds off while requests keep coming, so the input stalls
      if (i == 100) hold_asks <= hold_asks + 1;
      send_divisor(pick_divisor());
      if (i == 250) drain_results();
      else sender_gap();
    end

    drain_results();
    repeat (SETTLE) @(posedge clk);
    sb.mismatches += sb.pending();

    $display("checked %0d results: %0d zero divisors, %0d powers of two, %0d rounded down,",
             sb.checked, sb.n_zero, sb.n_pow2, sb.n_down);
    $display("  %0d rounded up; %0d mismatches", sb.n_up, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/dmn_pkg.sv
hdl/dmn_ucode_rom.sv
hdl/dmn_sequencer.sv
hdl/dmn_datapath.sv
hdl/division_magic_number_calc.sv
tb/division_magic_number_calc_tb.sv
